// ===== rtl/core/wicst_pkg.sv =====
// wicst_pkg: shared constants, types and the per-chunk update rule for the
// write-intent chunk state table. No dependencies.
`timescale 1ns / 1ps

package wicst_pkg;

  // table geometry
  localparam int MAX_CHUNKS  = 4096;
  localparam int IDX_W       = $clog2(MAX_CHUNKS);
  localparam int CNT_W       = 13;
  localparam int SHIFT_W     = 5;
  localparam int SYNC_WINDOW = 8;

  // stream payload widths
  localparam int CMD_W   = 3;
  localparam int OFF_W   = 48;
  localparam int SECT_W  = 32;
  localparam int BLK_W   = 32;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 40;
  localparam int CFG_W   = 13;

  // configuration register indexes
  localparam logic CFG_CHUNK_SHIFT = 1'b0;
  localparam logic CFG_CHUNK_COUNT = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE_MARK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD         = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DAEMON_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SYNC_QUERY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SYNC_END     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SYNC_CLOSE   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MARK_ALL     = 3'd6;

  // chunk states
  localparam logic [1:0] ST_CLEAN  = 2'd0;
  localparam logic [1:0] ST_DIRTY  = 2'd1;
  localparam logic [1:0] ST_RESYNC = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_CLIP,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic calc;
    logic clip;
    logic issue;
    logic clear_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic issue_last;
    logic clear_last;
  } dp_status_t;

  function automatic logic [1:0] next_chunk_state(input logic [CMD_W-1:0] cmd,
                                                  input logic [1:0] st);
    logic [1:0] res;
    res = st;
    case (cmd)
      CMD_WRITE_MARK, CMD_MARK_ALL: begin
        if (st != ST_DIRTY && st != ST_RESYNC) res = ST_DIRTY;
      end
      CMD_LOAD: begin
        if (st == ST_DIRTY) res = ST_RESYNC;
      end
      CMD_DAEMON_CLEAR: begin
        if (st == ST_DIRTY) res = ST_CLEAN;
      end
      CMD_SYNC_END, CMD_SYNC_CLOSE: begin
        if (st == ST_RESYNC) res = ST_DIRTY;
      end
      default: res = st;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/wicst_dpath.sv =====
// wicst_dpath: configuration registers, chunk state memory, range setup,
// walk counter, sync totals and the output word register.
// Depends on wicst_pkg.
`timescale 1ns / 1ps

module wicst_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wicst_pkg::CFG_W-1:0]    cfg_data,
  input  logic [wicst_pkg::IN_W-1:0]     s_tdata,
  input  wicst_pkg::ctrl_cmd_t           cmd,
  output wicst_pkg::dp_status_t          sts,
  output logic [wicst_pkg::OUT_W-1:0]    m_tdata
);

  localparam int IDX_W = wicst_pkg::IDX_W;

  logic [wicst_pkg::SHIFT_W-1:0] chunk_shift;
  logic [wicst_pkg::CNT_W-1:0]   chunk_count;

  logic [wicst_pkg::CMD_W-1:0]   cmd_q;
  logic [wicst_pkg::OFF_W-1:0]   off_q;
  logic [wicst_pkg::SECT_W-1:0]  cnt_q;
  logic [wicst_pkg::OFF_W-1:0]   lo_q;
  logic [wicst_pkg::OFF_W:0]     hi_q;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last;
  logic [wicst_pkg::BLK_W-1:0] total;
  logic need;

  logic             p_valid;
  logic [IDX_W-1:0] p_addr;
  logic [1:0]       rdata;
  logic [1:0]       mem [wicst_pkg::MAX_CHUNKS];

  logic                        out_need;
  logic [wicst_pkg::BLK_W-1:0] out_blocks;

  logic [wicst_pkg::CNT_W-1:0]  n_live;
  logic [IDX_W-1:0]             n_m1;
  logic                         n_zero;
  logic                         lo_out;
  logic                         hi_out;
  logic [IDX_W-1:0]             first_c;
  logic [IDX_W-1:0]             last_c;
  logic                         empty_c;
  logic [wicst_pkg::BLK_W-1:0]  csize;
  logic [wicst_pkg::BLK_W:0]    sum;
  logic [wicst_pkg::BLK_W-1:0]  total_next;
  logic                         counts_total;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_shift <= wicst_pkg::SHIFT_W'(3);
      chunk_count <= wicst_pkg::CNT_W'(wicst_pkg::MAX_CHUNKS);
    end else if (cfg_we) begin
      case (cfg_index)
        wicst_pkg::CFG_CHUNK_SHIFT: chunk_shift <= cfg_data[wicst_pkg::SHIFT_W-1:0];
        wicst_pkg::CFG_CHUNK_COUNT: chunk_count <= cfg_data[wicst_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_live = (chunk_count > wicst_pkg::CNT_W'(wicst_pkg::MAX_CHUNKS)) ?
                  wicst_pkg::CNT_W'(wicst_pkg::MAX_CHUNKS) : chunk_count;
  assign n_zero = (n_live == '0);
  assign n_m1   = IDX_W'(n_live - wicst_pkg::CNT_W'(1));
  assign lo_out = (lo_q >= wicst_pkg::OFF_W'(n_live));
  assign hi_out = (hi_q >= (wicst_pkg::OFF_W+1)'(n_live));

  // clipped walk range per command
  always_comb begin
    first_c = '0;
    last_c  = n_m1;
    empty_c = n_zero;
    case (cmd_q)
      wicst_pkg::CMD_WRITE_MARK: begin
        first_c = lo_q[IDX_W-1:0];
        last_c  = hi_out ? n_m1 : hi_q[IDX_W-1:0];
        empty_c = n_zero || lo_out;
      end
      wicst_pkg::CMD_LOAD, wicst_pkg::CMD_DAEMON_CLEAR,
      wicst_pkg::CMD_SYNC_CLOSE, wicst_pkg::CMD_MARK_ALL: begin
        first_c = '0;
        last_c  = n_m1;
        empty_c = n_zero;
      end
      wicst_pkg::CMD_SYNC_QUERY: begin
        first_c = lo_q[IDX_W-1:0];
        last_c  = n_m1;
        empty_c = n_zero || lo_out;
      end
      wicst_pkg::CMD_SYNC_END: begin
        first_c = '0;
        last_c  = lo_out ? n_m1 : lo_q[IDX_W-1:0];
        empty_c = n_zero;
      end
      default: begin
        empty_c = 1'b1;
      end
    endcase
  end

  // saturating running total, one chunk size per chunk visited by sync query or sync end
  assign csize        = wicst_pkg::BLK_W'(1) << chunk_shift;
  assign sum          = {1'b0, total} + {1'b0, csize};
  assign total_next   = sum[wicst_pkg::BLK_W] ? '1 : sum[wicst_pkg::BLK_W-1:0];
  assign counts_total = (cmd_q == wicst_pkg::CMD_SYNC_QUERY) ||
                        (cmd_q == wicst_pkg::CMD_SYNC_END);

  assign sts.empty      = empty_c;
  assign sts.issue_last = (idx == last) ||
                          ((cmd_q == wicst_pkg::CMD_SYNC_QUERY) &&
                           (total_next >= wicst_pkg::BLK_W'(wicst_pkg::SYNC_WINDOW)));
  assign sts.clear_last = (idx == IDX_W'(wicst_pkg::MAX_CHUNKS - 1));

  // word payload and range setup
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q <= s_tdata[2:0];
      off_q <= s_tdata[50:3];
      cnt_q <= s_tdata[82:51];
    end
    if (cmd.calc) begin
      lo_q <= off_q >> chunk_shift;
      hi_q <= ({1'b0, off_q} + (wicst_pkg::OFF_W+1)'(cnt_q)) >> chunk_shift;
    end
    if (cmd.clip) begin
      last <= last_c;
    end
  end

  // walk counter, read pipeline valid and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      p_valid <= 1'b0;
      need    <= 1'b0;
      total   <= '0;
    end else begin
      p_valid <= cmd.issue;
      if (cmd.latch) begin
        need  <= 1'b0;
        total <= '0;
      end
      if (cmd.clip) begin
        idx <= first_c;
      end else if (cmd.issue || cmd.clear_step) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.issue && counts_total) begin
        total <= total_next;
      end
      if (p_valid && cmd_q == wicst_pkg::CMD_SYNC_QUERY && rdata == wicst_pkg::ST_RESYNC) begin
        need <= 1'b1;
      end
    end
  end

  // chunk state memory: read at the walk index, write back in the next cycle
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata  <= mem[idx];
      p_addr <= idx;
    end
    if (cmd.clear_step) begin
      mem[idx] <= wicst_pkg::ST_CLEAN;
    end else if (p_valid) begin
      mem[p_addr] <= wicst_pkg::next_chunk_state(cmd_q, rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_need   <= need;
      out_blocks <= total;
    end
  end

  assign m_tdata = {7'b0, out_blocks, out_need};

endmodule

// ===== rtl/core/wicst_ctrl.sv =====
// wicst_ctrl: sequencer for the chunk state table: clearing pass, range
// setup, memory walk and output handshake. Depends on wicst_pkg.
`timescale 1ns / 1ps

module wicst_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  wicst_pkg::dp_status_t  sts,
  output wicst_pkg::ctrl_cmd_t   cmd
);

  wicst_pkg::state_t state, state_next;
  logic out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wicst_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      wicst_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = wicst_pkg::S_IDLE;
      end
      wicst_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = wicst_pkg::S_CALC;
        end
      end
      wicst_pkg::S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = wicst_pkg::S_CLIP;
      end
      wicst_pkg::S_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = sts.empty ? wicst_pkg::S_FINISH : wicst_pkg::S_WALK;
      end
      wicst_pkg::S_WALK: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) state_next = wicst_pkg::S_DRAIN;
      end
      wicst_pkg::S_DRAIN: begin
        // last write-back and resync check land here
        state_next = wicst_pkg::S_FINISH;
      end
      wicst_pkg::S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = wicst_pkg::S_IDLE;
        end
      end
      default: state_next = wicst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  assign m_tvalid = out_valid;

`ifndef NO_ASSERTIONS
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("output word overwritten before it was taken");

  a_walk_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && sts.issue_last) |=> !cmd.issue)
    else $error("walk continued past its last chunk");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> out_valid)
    else $error("pending result dropped");

  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> (!cmd.issue && !s_tready))
    else $error("clearing pass overlapped other work");
`endif

endmodule

// ===== rtl/core/write_intent_chunk_state_table_unit.sv =====
// write_intent_chunk_state_table_unit: top level of the write-intent chunk
// state table. Depends on wicst_pkg, wicst_ctrl and wicst_dpath.
`timescale 1ns / 1ps

// After reset the block runs a clearing pass over all 4096 table entries,
// one per cycle, and takes the first word only after it (configuration writes
// are taken during that pass). Each command runs three setup steps (accept,
// shift, range clip), walks chunks one per cycle through the single-port-read
// state memory, then drains and loads the output register: write mark walks
// from the offset's chunk to the chunk of offset plus count, sync query from
// the offset's chunk until the total reaches SYNC_WINDOW or the last chunk,
// sync end from chunk 0 up to the offset's chunk, and load, daemon clear, sync
// close and mark all over chunk_count chunks. Empty ranges and unused commands
// skip the walk. One command is in flight at a time; a finished result waits
// in the output register while the next command is accepted.

module write_intent_chunk_state_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [wicst_pkg::CFG_W-1:0]   cfg_data,
  // command words
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wicst_pkg::IN_W-1:0]    s_tdata,  // command[2:0], sector_offset[50:3], sector_count[82:51]
  // result words
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wicst_pkg::OUT_W-1:0]   m_tdata   // need_sync[0], sync_blocks[32:1]
);

  wicst_pkg::ctrl_cmd_t  cmd;
  wicst_pkg::dp_status_t sts;

  wicst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wicst_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .m_tdata   (m_tdata)
  );

endmodule
